// ===== design/ldq_pkg.sv =====
// ----------------------------------------------------------------------------
// ldq_pkg
// Shared types and codes of the linear-array deque: operation kinds, result
// status codes and the command item passed from front to back.
// ----------------------------------------------------------------------------
`default_nettype none

package ldq_pkg;

    localparam int VALUE_W    = 32;
    localparam int KIND_W     = 3;
    localparam int STATUS_W   = 2;
    localparam int CMDQ_DEPTH = 2;

    // Operation kinds as they arrive on the input channel
    localparam logic [KIND_W-1:0] KIND_INS_FRONT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DEL_FRONT = 3'd1;
    localparam logic [KIND_W-1:0] KIND_INS_REAR  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DEL_REAR  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DUMP      = 3'd4;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REFUSED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;

    typedef enum logic [2:0] {
        OP_INS_FRONT,
        OP_DEL_FRONT,
        OP_INS_REAR,
        OP_DEL_REAR,
        OP_DUMP
    } op_t;

    typedef struct packed {
        op_t                       op;
        logic signed [VALUE_W-1:0] value;
    } cmd_t;

endpackage

`default_nettype wire

// ===== design/ldq_front.sv =====
// ----------------------------------------------------------------------------
// ldq_front
// Accepts input items, decodes the kind into an operation and holds the
// decoded commands in a short queue for the back end. Unused kinds are
// accepted and dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module ldq_front
    import ldq_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [KIND_W-1:0]          kind,
    input  wire logic signed [VALUE_W-1:0]  value,
    output logic                            cmd_valid,
    input  wire logic                       cmd_stall,
    output cmd_t                            cmd
);

    localparam int QPW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int QCW = $clog2(CMDQ_DEPTH + 1);

    cmd_t           q_mem [CMDQ_DEPTH];
    logic [QPW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0] count_reg, count_next;
    logic           known;
    op_t            op;
    logic           push, pop;

    always_comb
    begin
        known = 1'b1;
        op    = OP_DUMP;
        case (kind)
            KIND_INS_FRONT: op = OP_INS_FRONT;
            KIND_DEL_FRONT: op = OP_DEL_FRONT;
            KIND_INS_REAR:  op = OP_INS_REAR;
            KIND_DEL_REAR:  op = OP_DEL_REAR;
            KIND_DUMP:      op = OP_DUMP;
            default:        known = 1'b0;
        endcase
    end

    assign in_stall  = (count_reg == QCW'(CMDQ_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = q_mem[rd_ptr_reg];

    assign push = in_valid && !in_stall && known;
    assign pop  = cmd_valid && !cmd_stall;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= '{op: op, value: value};
        end
    end

endmodule

`default_nettype wire

// ===== design/ldq_back.sv =====
// ----------------------------------------------------------------------------
// ldq_back
// Executes deque commands against the element store: keeps the head and
// tail indices, writes inserts, reads deletes and walks the store for a
// dump. Results leave through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ldq_back
    import ldq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cmd_valid,
    output logic                            cmd_stall,
    input  wire cmd_t                       cmd,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [STATUS_W-1:0]             status,
    output logic signed [VALUE_W-1:0]       data,
    output logic                            last
);

    localparam int IW = $clog2(DEPTH);
    localparam int TW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EMIT = 2'b10
    } back_state_t;

    back_state_t state_reg, state_next;
    logic [IW-1:0] head_reg, head_next;
    logic [TW-1:0] tail_reg, tail_next;
    logic [IW-1:0] ptr_reg, ptr_next;
    logic          last_reg, last_next;

    logic [VALUE_W-1:0] store_mem [DEPTH];
    logic [VALUE_W-1:0] rd_data_reg;
    logic               wr_en, rd_en;
    logic [IW-1:0]      wr_addr, rd_addr;
    logic [VALUE_W-1:0] wr_data;

    logic                      out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]       out_status_reg;
    logic signed [VALUE_W-1:0] out_data_reg;
    logic                      out_last_reg;

    logic                      emit;
    logic [STATUS_W-1:0]       emit_status;
    logic [VALUE_W-1:0]        emit_data;
    logic                      emit_last;

    logic          can_emit, empty, head_at_zero, tail_full;
    logic [TW-1:0] head_ext, head_inc, tail_dec, ptr_inc;

    assign can_emit     = !out_valid_reg || !out_stall;
    assign empty        = (tail_reg == '0);
    assign head_at_zero = (head_reg == '0);
    assign tail_full    = (tail_reg == TW'(DEPTH));
    assign head_ext     = TW'(head_reg);
    assign head_inc     = head_ext + 1'b1;
    assign tail_dec     = tail_reg - 1'b1;
    assign ptr_inc      = TW'(ptr_reg) + 1'b1;

    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        ptr_next    = ptr_reg;
        last_next   = last_reg;
        cmd_stall   = 1'b1;
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = cmd.value;
        rd_en       = 1'b0;
        rd_addr     = '0;
        emit        = 1'b0;
        emit_status = ST_OK;
        emit_data   = '0;
        emit_last   = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.op)
                        OP_INS_FRONT:
                        begin
                            if (can_emit)
                            begin
                                cmd_stall = 1'b0;
                                emit      = 1'b1;
                                if (!empty && head_at_zero)
                                begin
                                    emit_status = ST_REFUSED;
                                end
                                else if (empty)
                                begin
                                    // empty queue: place at the rear, slot zero
                                    wr_en     = 1'b1;
                                    wr_addr   = '0;
                                    tail_next = TW'(1);
                                end
                                else
                                begin
                                    wr_en     = 1'b1;
                                    wr_addr   = head_reg - 1'b1;
                                    head_next = head_reg - 1'b1;
                                end
                            end
                        end
                        OP_INS_REAR:
                        begin
                            if (can_emit)
                            begin
                                cmd_stall = 1'b0;
                                emit      = 1'b1;
                                if (tail_full)
                                begin
                                    emit_status = ST_REFUSED;
                                end
                                else
                                begin
                                    wr_en     = 1'b1;
                                    wr_addr   = IW'(tail_reg);
                                    tail_next = tail_reg + 1'b1;
                                end
                            end
                        end
                        OP_DEL_FRONT:
                        begin
                            if (empty)
                            begin
                                if (can_emit)
                                begin
                                    cmd_stall   = 1'b0;
                                    emit        = 1'b1;
                                    emit_status = ST_EMPTY;
                                end
                            end
                            else
                            begin
                                cmd_stall  = 1'b0;
                                rd_en      = 1'b1;
                                rd_addr    = head_reg;
                                last_next  = 1'b1;
                                state_next = S_EMIT;
                                if (head_inc >= tail_reg)
                                begin
                                    head_next = '0;
                                    tail_next = '0;
                                end
                                else
                                begin
                                    head_next = head_reg + 1'b1;
                                end
                            end
                        end
                        OP_DEL_REAR:
                        begin
                            if (empty)
                            begin
                                if (can_emit)
                                begin
                                    cmd_stall   = 1'b0;
                                    emit        = 1'b1;
                                    emit_status = ST_EMPTY;
                                end
                            end
                            else
                            begin
                                cmd_stall  = 1'b0;
                                rd_en      = 1'b1;
                                rd_addr    = IW'(tail_dec);
                                last_next  = 1'b1;
                                state_next = S_EMIT;
                                if (tail_dec <= head_ext)
                                begin
                                    head_next = '0;
                                    tail_next = '0;
                                end
                                else
                                begin
                                    tail_next = tail_dec;
                                end
                            end
                        end
                        OP_DUMP:
                        begin
                            if (empty)
                            begin
                                if (can_emit)
                                begin
                                    cmd_stall   = 1'b0;
                                    emit        = 1'b1;
                                    emit_status = ST_EMPTY;
                                end
                            end
                            else
                            begin
                                cmd_stall  = 1'b0;
                                rd_en      = 1'b1;
                                rd_addr    = head_reg;
                                ptr_next   = head_reg;
                                last_next  = (head_inc == tail_reg);
                                state_next = S_EMIT;
                            end
                        end
                        default:
                        begin
                            // drop anything undecodable
                            cmd_stall = 1'b0;
                        end
                    endcase
                end
            end
            S_EMIT:
            begin
                if (can_emit)
                begin
                    emit        = 1'b1;
                    emit_status = ST_OK;
                    emit_data   = rd_data_reg;
                    emit_last   = last_reg;
                    if (last_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        // advance the dump walk, next element lands next cycle
                        ptr_next  = IW'(ptr_inc);
                        rd_en     = 1'b1;
                        rd_addr   = IW'(ptr_inc);
                        last_next = ((ptr_inc + 1'b1) == tail_reg);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            ptr_reg       <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            ptr_reg       <= ptr_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_status_reg <= emit_status;
            out_data_reg   <= emit_data;
            out_last_reg   <= emit_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign data      = out_data_reg;
    assign last      = out_last_reg;

    a_head_below_tail: assert property (@(posedge clk) disable iff (!rst_n)
        (tail_reg != '0) |-> (TW'(head_reg) < tail_reg))
        else $error("head index not below tail on a non-empty queue");

    a_empty_head_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (tail_reg == '0) |-> (head_reg == '0))
        else $error("empty queue with head index away from zero");

    a_nonok_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg != ST_OK)) |-> (out_data_reg == '0))
        else $error("result with non-ok status carries data");

    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_EMIT) && !last_reg) |-> ((TW'(ptr_reg) + 1'b1) < tail_reg))
        else $error("dump walk ran past the tail");

endmodule

`default_nettype wire

// ===== design/linear_array_deque.sv =====
// Double-ended queue in a fixed, non-circular array of DEPTH 32-bit entries.
// Each item carries a kind (insert front, delete front, insert rear, delete
// rear, dump) and a value; kinds 5 to 7 are taken and produce no result.
// Items enter a two-entry command queue, so the input keeps flowing while
// the back end works or a result waits. Inserts and refused or empty
// operations run at one item per cycle unless the output stalls. A
// successful delete or dump reads each element through the registered store
// read port and takes no new command until its last result. Every item
// yields at least one result except the unused kinds; the final result of an
// item has last set. Data is zero whenever status is not ok and on inserts.
// ----------------------------------------------------------------------------
// linear_array_deque
// Top level: input decode and command queue in front, deque execution and
// element store behind it.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_array_deque
    import ldq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [KIND_W-1:0]          kind,
    input  wire logic signed [VALUE_W-1:0]  value,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [STATUS_W-1:0]             status,
    output logic signed [VALUE_W-1:0]       data,
    output logic                            last
);

    logic cmd_valid;
    logic cmd_stall;
    cmd_t cmd;

    ldq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .value     (value),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd)
    );

    ldq_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .data      (data),
        .last      (last)
    );

endmodule

`default_nettype wire

// ===== test/ldq_checker.sv =====
// ----------------------------------------------------------------------------
// ldq_checker
// Watches both channels of the linear-array deque. It keeps its own copy of
// the element store and the head and tail indices, predicts the results of
// every accepted item, and compares each accepted result field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module ldq_checker
    import ldq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    input  wire logic                      in_stall,
    input  wire logic [KIND_W-1:0]         kind,
    input  wire logic signed [VALUE_W-1:0] value,
    input  wire logic                      out_valid,
    input  wire logic                      out_stall,
    input  wire logic [STATUS_W-1:0]       status,
    input  wire logic signed [VALUE_W-1:0] data,
    input  wire logic                      last,
    output int                             err_count,
    output int                             pending
);

    typedef struct {
        logic [STATUS_W-1:0]       status;
        logic signed [VALUE_W-1:0] data;
        logic                      last;
    } deque_result_t;

    deque_result_t             expected_results[$];
    logic signed [VALUE_W-1:0] slots [DEPTH];
    int unsigned               head_idx;
    int unsigned               tail_nxt;

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        err_count++;
    endtask

    function automatic void push_result(input logic [STATUS_W-1:0] st,
                                        input logic signed [VALUE_W-1:0] d,
                                        input logic fin);
        deque_result_t r;
        r.status = st;
        r.data   = d;
        r.last   = fin;
        expected_results.push_back(r);
    endfunction

    // Both indices go back to the start once a delete empties the queue
    function automatic void rewind_if_empty();
        if (head_idx >= tail_nxt)
        begin
            head_idx = 0;
            tail_nxt = 0;
        end
    endfunction

    task automatic predict_deque_op(input logic [KIND_W-1:0] op,
                                    input logic signed [VALUE_W-1:0] v);
        bit is_empty;
        is_empty = (head_idx >= tail_nxt);
        case (op)
            KIND_INS_FRONT:
            begin
                if (!is_empty && head_idx == 0)
                    push_result(ST_REFUSED, '0, 1'b1);
                else
                begin
                    // empty queue: the item lands at the rear
                    if (head_idx == 0)
                    begin
                        if (tail_nxt < DEPTH)
                        begin
                            slots[tail_nxt] = v;
                            tail_nxt++;
                        end
                    end
                    else
                    begin
                        head_idx--;
                        slots[head_idx] = v;
                    end
                    push_result(ST_OK, '0, 1'b1);
                end
            end
            KIND_DEL_FRONT:
            begin
                if (is_empty)
                    push_result(ST_EMPTY, '0, 1'b1);
                else
                begin
                    push_result(ST_OK, slots[head_idx], 1'b1);
                    head_idx++;
                    rewind_if_empty();
                end
            end
            KIND_INS_REAR:
            begin
                if (tail_nxt >= DEPTH)
                    push_result(ST_REFUSED, '0, 1'b1);
                else
                begin
                    slots[tail_nxt] = v;
                    tail_nxt++;
                    push_result(ST_OK, '0, 1'b1);
                end
            end
            KIND_DEL_REAR:
            begin
                if (is_empty)
                    push_result(ST_EMPTY, '0, 1'b1);
                else
                begin
                    tail_nxt--;
                    push_result(ST_OK, slots[tail_nxt], 1'b1);
                    rewind_if_empty();
                end
            end
            KIND_DUMP:
            begin
                if (is_empty)
                    push_result(ST_EMPTY, '0, 1'b1);
                else
                    for (int unsigned i = head_idx; i < tail_nxt; i++)
                        push_result(ST_OK, slots[i], (i + 1 >= tail_nxt));
            end
            default: ;  // unused kinds: drop silently
        endcase
    endtask

    task automatic check_result();
        deque_result_t want;
        if (expected_results.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result status %0d data %0d last %0b",
                                      status, data, last));
            return;
        end
        want = expected_results.pop_front();
        if (status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
        if (data !== want.data)
            report_mismatch($sformatf("data %0d, expected %0d", data, want.data));
        if (last !== want.last)
            report_mismatch($sformatf("last %0b, expected %0b", last, want.last));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_idx  = 0;
            tail_nxt  = 0;
            err_count = 0;
            expected_results.delete();
            pending   = 0;
        end
        else
        begin
            // predict first so a same-edge result always finds its item
            if (in_valid && !in_stall)
                predict_deque_op(kind, value);
            if (out_valid && !out_stall)
                check_result();
            pending = expected_results.size();
        end
    end

endmodule

`default_nettype wire

// ===== test/linear_array_deque_tb.sv =====
// ----------------------------------------------------------------------------
// linear_array_deque_tb
// Drives the deque with a short directed sequence covering empty, full and
// refused cases, then with random fill and drain bursts under several
// sender and receiver idling mixes. The checker does all comparison.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_array_deque_tb;
    import ldq_pkg::*;

    localparam int DEPTH          = 16;
    localparam int HOLD_CYCLES    = 300;
    localparam int TAIL_CYCLES    = 40;
    localparam int WATCHDOG_LIMIT = 2000;

    localparam logic [KIND_W-1:0]          KIND_RSVD_LO  = 3'd5;
    localparam logic [KIND_W-1:0]          KIND_RSVD_MID = 3'd6;
    localparam logic [KIND_W-1:0]          KIND_RSVD_HI  = 3'd7;
    localparam logic signed [VALUE_W-1:0]  VAL_MAX       = 32'sh7FFF_FFFF;
    localparam logic signed [VALUE_W-1:0]  VAL_MIN       = 32'sh8000_0000;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      in_valid  = 1'b0;
    logic [KIND_W-1:0]         kind      = '0;
    logic signed [VALUE_W-1:0] value     = '0;
    logic                      out_stall = 1'b0;
    wire logic                 in_stall;
    wire logic                 out_valid;
    wire logic [STATUS_W-1:0]  status;
    wire logic signed [VALUE_W-1:0] data;
    wire logic                 last;

    int err_count;
    int pending;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    bit hold_req      = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    linear_array_deque #(.DEPTH(DEPTH)) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .data      (data),
        .last      (last)
    );

    ldq_checker #(.DEPTH(DEPTH)) u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .data      (data),
        .last      (last),
        .err_count (err_count),
        .pending   (pending)
    );

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send_item(input logic [KIND_W-1:0] k,
                             input logic signed [VALUE_W-1:0] v);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        value    <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
    endtask

    task automatic run_directed();
        send_item(KIND_DEL_FRONT, '0);
        send_item(KIND_DEL_REAR, '0);
        send_item(KIND_DUMP, '0);
        // front insert into an empty queue goes to the rear
        send_item(KIND_INS_FRONT, VAL_MIN);
        // head at zero with an element: refused
        send_item(KIND_INS_FRONT, VAL_MAX);
        send_item(KIND_RSVD_LO, VAL_MAX);
        send_item(KIND_RSVD_MID, '1);
        send_item(KIND_RSVD_HI, VAL_MIN);
        // empties the queue and rewinds the indices
        send_item(KIND_DEL_FRONT, '0);
        for (int i = 0; i < DEPTH; i++)
        begin
            if (i == 0)
                send_item(KIND_INS_REAR, VAL_MAX);
            else if (i == 1)
                send_item(KIND_INS_REAR, VAL_MIN);
            else if (i == 2)
                send_item(KIND_INS_REAR, -32'sd1);
            else
                send_item(KIND_INS_REAR, $urandom);
        end
        send_item(KIND_INS_REAR, 32'sd5);
        send_item(KIND_DEL_FRONT, '0);
        // tail past the last slot refuses even with room below the head
        send_item(KIND_INS_REAR, 32'sd6);
        send_item(KIND_INS_FRONT, 32'sd0);
        send_item(KIND_DUMP, '0);
        send_item(KIND_DEL_REAR, '0);
    endtask

    // Bursts lean toward filling or draining so both ends get hit often
    task automatic run_traffic(input int n_items);
        int                        fill_pct;
        int                        roll;
        logic [KIND_W-1:0]         k;
        logic signed [VALUE_W-1:0] v;
        fill_pct = 50;
        for (int i = 0; i < n_items; i++)
        begin
            if (i % 24 == 0)
                fill_pct = ($urandom_range(1) != 0) ? 80 : 25;
            roll = $urandom_range(99);
            if (roll < 3)
                k = KIND_W'($urandom_range(KIND_RSVD_HI, KIND_RSVD_LO));
            else if (roll < 11)
                k = KIND_DUMP;
            else if ($urandom_range(99) < fill_pct)
                k = ($urandom_range(1) != 0) ? KIND_INS_FRONT : KIND_INS_REAR;
            else
                k = ($urandom_range(1) != 0) ? KIND_DEL_FRONT : KIND_DEL_REAR;
            case ($urandom_range(11))
                0:       v = VAL_MAX;
                1:       v = VAL_MIN;
                2:       v = '0;
                3:       v = -32'sd1;
                default: v = $urandom;
            endcase
            send_item(k, v);
        end
    endtask

    initial
    begin : receiver
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++)
                begin
                    out_stall <= 1'b1;
                    @(negedge clk);
                end
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin : stimulus
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        run_directed();
        wait_drained();

        // no idling, with one long receiver hold-off in the middle
        run_traffic(30);
        hold_req = 1'b1;
        run_traffic(50);
        wait_drained();

        send_idle_pct = 66;
        stall_pct     = 0;
        run_traffic(80);
        wait_drained();

        send_idle_pct = 0;
        stall_pct     = 66;
        run_traffic(80);
        wait_drained();

        send_idle_pct = 8;
        stall_pct     = 8;
        run_traffic(80);
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (err_count == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
design/ldq_pkg.sv
design/ldq_front.sv
design/ldq_back.sv
design/linear_array_deque.sv
test/ldq_checker.sv
test/linear_array_deque_tb.sv
